// ===== rtl/pfe_pkg.sv =====
// Shared types, constants and letter helpers for the Playfair digraph encryptor.
// No dependencies; imported by every module of the block.
package pfe_pkg;

    localparam int SQUARE_SIZE = 25;
    localparam int SIDE        = 5;
    localparam int LETTERS     = 26;
    localparam logic [4:0] PAD_INDEX = 5'd23;
    localparam logic [6:0] ASCII_A   = 7'd97;
    localparam logic [6:0] ASCII_Z   = 7'd122;

    typedef struct packed {
        logic [6:0] kept;
        logic [6:0] dropped;
    } cfg_t;

    typedef enum logic [1:0] {
        CMD_PLACE,
        CMD_FILL,
        CMD_ENC
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t    op;
        logic [4:0] a;
        logic [4:0] b;
    } cmd_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_FILL,
        BK_ENC_SQ,
        BK_RESULT
    } back_state_t;

    function automatic logic is_lower(input logic [6:0] v);
        return (v >= ASCII_A) && (v <= ASCII_Z);
    endfunction

    function automatic logic [4:0] lower_index(input logic [6:0] v);
        logic [6:0] diff;
        diff = v - ASCII_A;
        return diff[4:0];
    endfunction

endpackage

// ===== rtl/pfe_front.sv =====
// Front end: accepts beats, folds and maps letters, pairs text letters.
// Depends on pfe_pkg; pushes commands into pfe_queue.
module pfe_front (
    input  logic          aclk,
    input  logic          aresetn,
    input  pfe_pkg::cfg_t cfg,
    input  logic          s_valid,
    output logic          s_ready,
    input  logic [1:0]    s_mode,
    input  logic [7:0]    s_ch,
    input  logic          q_full,
    output logic          q_push,
    output pfe_pkg::cmd_t q_cmd
);
    import pfe_pkg::*;

    localparam logic [1:0] MODE_KEY      = 2'd0;
    localparam logic [1:0] MODE_KEY_END  = 2'd1;
    localparam logic [1:0] MODE_TEXT     = 2'd2;
    localparam logic [1:0] MODE_TEXT_END = 2'd3;

    logic [4:0] held_letter_reg, held_letter_next;
    logic       held_valid_reg, held_valid_next;
    logic       accept;
    logic       fold_valid, map_valid;
    logic [4:0] fold_idx, map_idx;
    logic [7:0] ch_diff;
    logic       gen;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    always_comb begin
        fold_valid = 1'b0;
        ch_diff    = 8'd0;
        if (s_ch >= 8'd97 && s_ch <= 8'd122) begin
            fold_valid = 1'b1;
            ch_diff    = s_ch - 8'd97;
        end else if (s_ch >= 8'd65 && s_ch <= 8'd90) begin
            fold_valid = 1'b1;
            ch_diff    = s_ch - 8'd65;
        end
        fold_idx = ch_diff[4:0];
    end

    always_comb begin
        map_valid = fold_valid;
        map_idx   = fold_idx;
        if (is_lower(cfg.dropped) && fold_idx == lower_index(cfg.dropped)) begin
            map_valid = fold_valid && is_lower(cfg.kept);
            map_idx   = lower_index(cfg.kept);
        end
    end

    always_comb begin
        gen              = 1'b0;
        q_cmd.op         = CMD_PLACE;
        q_cmd.a          = map_idx;
        q_cmd.b          = map_idx;
        held_letter_next = held_letter_reg;
        held_valid_next  = held_valid_reg;
        unique case (s_mode)
            MODE_KEY: begin
                gen = map_valid;
            end
            MODE_KEY_END: begin
                gen      = 1'b1;
                q_cmd.op = CMD_FILL;
            end
            MODE_TEXT: begin
                q_cmd.op = CMD_ENC;
                q_cmd.a  = held_letter_reg;
                if (map_valid) begin
                    if (!held_valid_reg) begin
                        held_letter_next = map_idx;
                        held_valid_next  = 1'b1;
                    end else if (map_idx == held_letter_reg) begin
                        gen     = 1'b1;
                        q_cmd.b = PAD_INDEX;
                    end else begin
                        gen             = 1'b1;
                        held_valid_next = 1'b0;
                    end
                end
            end
            MODE_TEXT_END: begin
                q_cmd.op        = CMD_ENC;
                q_cmd.a         = held_letter_reg;
                q_cmd.b         = PAD_INDEX;
                gen             = held_valid_reg;
                held_valid_next = 1'b0;
            end
            default: begin
                gen = 1'b0;
            end
        endcase
    end

    assign q_push = accept && gen;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_letter_reg <= 5'd0;
            held_valid_reg  <= 1'b0;
        end else if (accept) begin
            held_letter_reg <= held_letter_next;
            held_valid_reg  <= held_valid_next;
        end
    end

endmodule

// ===== rtl/pfe_queue.sv =====
// Two-entry command queue between front end and back end.
// Depends on pfe_pkg for the command type.
module pfe_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  pfe_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output pfe_pkg::cmd_t pop_cmd,
    output logic          empty
);
    import pfe_pkg::*;

    localparam int DEPTH = 2;

    cmd_t       entry_mem [DEPTH];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;

    assign full    = (count_reg == 2'(DEPTH));
    assign empty   = (count_reg == 2'd0);
    assign pop_cmd = entry_mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push && !full) begin
            entry_mem[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push && !full) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop && !empty) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            unique case ({push && !full, pop && !empty})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

// ===== rtl/pfe_back.sv =====
// Back end: owns the square and position stores, places key letters,
// fills the square and enciphers pairs. Depends on pfe_pkg.
module pfe_back (
    input  logic          aclk,
    input  logic          aresetn,
    input  pfe_pkg::cfg_t cfg,
    input  logic          q_empty,
    input  pfe_pkg::cmd_t q_cmd,
    output logic          q_pop,
    output logic          m_valid,
    input  logic          m_ready,
    output logic [6:0]    m_cipher_first,
    output logic [6:0]    m_cipher_second,
    output logic          m_error
);
    import pfe_pkg::*;

    back_state_t state_reg, state_next;
    logic [LETTERS-1:0] used_reg, used_next;
    logic [4:0] fill_reg, fill_next;
    logic [4:0] fill_idx_reg, fill_idx_next;
    logic       err_reg, err_next;
    logic       m_valid_reg, m_valid_next;
    logic [6:0] m_first_reg, m_first_next;
    logic [6:0] m_second_reg, m_second_next;
    logic       m_error_reg, m_error_next;

    logic [4:0] sq_mem  [SQUARE_SIZE];
    logic [4:0] pos_mem [LETTERS];
    logic [4:0] pos_rd_a_reg, pos_rd_b_reg;
    logic [4:0] sq_rd_a_reg, sq_rd_b_reg;
    logic [4:0] sq_addr_a, sq_addr_b;

    logic       place_req, place_en;
    logic [4:0] place_letter;
    logic       d_valid;
    logic [4:0] d_idx;
    logic       out_free;
    logic [2:0] ra, ca, rb, cb;

    function automatic logic [2:0] pos_row(input logic [4:0] p);
        if (p >= 5'd20) return 3'd4;
        if (p >= 5'd15) return 3'd3;
        if (p >= 5'd10) return 3'd2;
        if (p >= 5'd5)  return 3'd1;
        return 3'd0;
    endfunction

    function automatic logic [4:0] mk_pos(input logic [2:0] r, input logic [2:0] c);
        return 5'({2'b00, r} * 5'(SIDE)) + {2'b00, c};
    endfunction

    function automatic logic [2:0] pos_col(input logic [4:0] p);
        logic [4:0] c;
        c = p - mk_pos(pos_row(p), 3'd0);
        return c[2:0];
    endfunction

    function automatic logic [2:0] wrap_inc(input logic [2:0] v);
        return (v == 3'(SIDE - 1)) ? 3'd0 : v + 3'd1;
    endfunction

    assign d_valid  = is_lower(cfg.dropped);
    assign d_idx    = lower_index(cfg.dropped);
    assign out_free = !m_valid_reg || m_ready;
    assign q_pop    = (state_reg == BK_IDLE) && !q_empty;

    always_comb begin
        place_req    = 1'b0;
        place_letter = q_cmd.a;
        if (state_reg == BK_IDLE && !q_empty && q_cmd.op == CMD_PLACE) begin
            place_req = 1'b1;
        end else if (state_reg == BK_FILL) begin
            place_letter = fill_idx_reg;
            place_req    = !(d_valid && fill_idx_reg == d_idx);
        end
    end

    assign place_en = place_req && !used_reg[place_letter] && (fill_reg < 5'(SQUARE_SIZE));

    always_comb begin
        ra = pos_row(pos_rd_a_reg);
        ca = pos_col(pos_rd_a_reg);
        rb = pos_row(pos_rd_b_reg);
        cb = pos_col(pos_rd_b_reg);
        if (ra == rb) begin
            sq_addr_a = mk_pos(ra, wrap_inc(ca));
            sq_addr_b = mk_pos(rb, wrap_inc(cb));
        end else if (ca == cb) begin
            sq_addr_a = mk_pos(wrap_inc(ra), ca);
            sq_addr_b = mk_pos(wrap_inc(rb), cb);
        end else begin
            sq_addr_a = mk_pos(ra, cb);
            sq_addr_b = mk_pos(rb, ca);
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE: begin
                if (!q_empty) begin
                    unique case (q_cmd.op)
                        CMD_FILL: state_next = BK_FILL;
                        CMD_ENC:  state_next = BK_ENC_SQ;
                        default:  state_next = BK_IDLE;
                    endcase
                end
            end
            BK_FILL: begin
                if (fill_idx_reg == 5'(LETTERS - 1)) begin
                    state_next = BK_IDLE;
                end
            end
            BK_ENC_SQ: state_next = BK_RESULT;
            BK_RESULT: begin
                if (out_free) begin
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    always_comb begin
        used_next     = used_reg;
        fill_next     = fill_reg;
        fill_idx_next = fill_idx_reg;
        err_next      = err_reg;
        m_valid_next  = m_valid_reg;
        m_first_next  = m_first_reg;
        m_second_next = m_second_reg;
        m_error_next  = m_error_reg;
        if (place_en) begin
            used_next[place_letter] = 1'b1;
            fill_next               = fill_reg + 5'd1;
        end
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        unique case (state_reg)
            BK_IDLE: begin
                fill_idx_next = 5'd0;
                err_next      = (fill_reg < 5'(SQUARE_SIZE)) || !used_reg[q_cmd.a]
                                || !used_reg[q_cmd.b];
            end
            BK_FILL: begin
                fill_idx_next = fill_idx_reg + 5'd1;
            end
            BK_RESULT: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_error_next  = err_reg;
                    m_first_next  = err_reg ? 7'd0 : ASCII_A + {2'b00, sq_rd_a_reg};
                    m_second_next = err_reg ? 7'd0 : ASCII_A + {2'b00, sq_rd_b_reg};
                end
            end
            default: begin
                err_next = err_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (place_en) begin
            sq_mem[fill_reg]      <= place_letter;
            pos_mem[place_letter] <= fill_reg;
        end
        pos_rd_a_reg <= pos_mem[q_cmd.a];
        pos_rd_b_reg <= pos_mem[q_cmd.b];
        if (state_reg == BK_ENC_SQ) begin
            sq_rd_a_reg <= sq_mem[sq_addr_a];
            sq_rd_b_reg <= sq_mem[sq_addr_b];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= BK_IDLE;
            used_reg     <= '0;
            fill_reg     <= 5'd0;
            fill_idx_reg <= 5'd0;
            err_reg      <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            used_reg     <= used_next;
            fill_reg     <= fill_next;
            fill_idx_reg <= fill_idx_next;
            err_reg      <= err_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_first_reg  <= m_first_next;
        m_second_reg <= m_second_next;
        m_error_reg  <= m_error_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_cipher_first  = m_first_reg;
    assign m_cipher_second = m_second_reg;
    assign m_error         = m_error_reg;

endmodule

// ===== rtl/playfair_digraph_encryptor.sv =====
// Top level of the Playfair digraph encryptor: APB register bank and wiring
// of pfe_front, pfe_queue and pfe_back. Depends on pfe_pkg.
//
//  channel | direction | beat fields                             | handshake
//  s_      | in        | s_mode, s_ch                            | s_valid / s_ready
//  m_      | out       | m_cipher_first, m_cipher_second, m_error| m_valid / m_ready
//  apb     | in        | paddr, pwdata (kept 0x0, dropped 0x4)   | psel, penable, pready
//
// Front takes one beat a cycle while the two-entry queue has room.
// Back: a key byte is placed as it is popped; key end pops, then one letter per cycle; a pair
// passes position read, square read and output register; a text byte without result pushes nothing.
// Synchronous active-low reset clears used letters, fill count and held letter;
// the square and position stores are not cleared.
// A stalled m_ side holds the back end in its result step; the queue then fills.
module playfair_digraph_encryptor (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_mode,
    input  logic [7:0]  s_ch,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [6:0]  m_cipher_first,
    output logic [6:0]  m_cipher_second,
    output logic        m_error
);
    import pfe_pkg::*;

    localparam logic REG_KEPT    = 1'b0;
    localparam logic REG_DROPPED = 1'b1;

    logic [6:0] kept_letter_reg, dropped_letter_reg;
    cfg_t       cfg;
    logic       q_full, q_push, q_pop, q_empty;
    cmd_t       push_cmd, pop_cmd;

    assign pready      = 1'b1;
    assign cfg.kept    = kept_letter_reg;
    assign cfg.dropped = dropped_letter_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kept_letter_reg    <= 7'd105;
            dropped_letter_reg <= 7'd106;
        end else if (psel && penable && pwrite && pready) begin
            unique case (paddr[2])
                REG_KEPT:    kept_letter_reg    <= pwdata[6:0];
                REG_DROPPED: dropped_letter_reg <= pwdata[6:0];
                default:     kept_letter_reg    <= kept_letter_reg;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_KEPT:    prdata = {25'd0, kept_letter_reg};
            REG_DROPPED: prdata = {25'd0, dropped_letter_reg};
            default:     prdata = 32'd0;
        endcase
    end

    pfe_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_mode  (s_mode),
        .s_ch    (s_ch),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_cmd   (push_cmd)
    );

    pfe_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .pop_cmd  (pop_cmd),
        .empty    (q_empty)
    );

    pfe_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg             (cfg),
        .q_empty         (q_empty),
        .q_cmd           (pop_cmd),
        .q_pop           (q_pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_cipher_first  (m_cipher_first),
        .m_cipher_second (m_cipher_second),
        .m_error         (m_error)
    );

endmodule
